// ----- hw/rtl/qfb_pkg.sv -----
// qfb_pkg: operation codes, reset values and float32 key helpers
// for the quantile feature binner. No dependencies.
package qfb_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int COLUMNS_DEF     = 64;
    localparam int MAX_BINS_DEF    = 256;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_BUILD  = 3'd1;
    localparam logic [2:0] OP_QUERY  = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_SETCNT = 3'd4;

    localparam logic [8:0] BIN_COUNT_RESET = 9'd256;

    function automatic logic is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    // order-preserving key, -0 folded onto +0
    function automatic logic [31:0] order_key(input logic [31:0] v);
        logic [31:0] w;
        w = (v == 32'h8000_0000) ? 32'd0 : v;
        return w[31] ? ~w : (w | 32'h8000_0000);
    endfunction

    function automatic logic [31:0] key_to_value(input logic [31:0] k);
        return k[31] ? (k ^ 32'h8000_0000) : ~k;
    endfunction

endpackage

// ----- hw/rtl/quantile_feature_binner.sv -----
// quantile_feature_binner: sample store, split builder and bin query
// sequencer around one compare unit. Depends on qfb_pkg.
//
// usage: one input channel (in_valid / in_stall) carries operation, column,
// value and index; one output channel (out_valid / out_stall) returns bin,
// split_total and status, one result per input transfer, in order.
// bin_count is written through cfg_write_en / cfg_write_data, by the user only
// while idle; the block does not enforce this. in_stall is low only while the
// sequencer is idle; one item at a time. load, write split and set count pass
// through the fetch and finish states, the result register loading as the finish
// state ends; a query adds a read state and a compare state per binary search
// step, the read state covering the registered split table port. a build scans
// the whole sample store once per distinct value plus one final pass, then picks
// and writes splits through the scratch port.
// reset clears the sample count, all column split counts and bin_count to 256;
// sample and split memories need no clearing pass.
// a stalled result stays in the output register; the sequencer finishes the
// next item and waits in its last state until the register frees up.
module quantile_feature_binner #(
    parameter int MAX_SAMPLES = qfb_pkg::MAX_SAMPLES_DEF,
    parameter int COLUMNS     = qfb_pkg::COLUMNS_DEF,
    parameter int MAX_BINS    = qfb_pkg::MAX_BINS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [8:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [5:0]  column,
    input  logic [31:0] value,
    input  logic [8:0]  index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  bin,
    output logic [8:0]  split_total,
    output logic        status
);
    import qfb_pkg::*;

    localparam int SAW  = $clog2(MAX_SAMPLES);
    localparam int STW  = $clog2(MAX_SAMPLES + 1);
    localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int BW   = $clog2(MAX_BINS);
    localparam int CNTW = $clog2(MAX_BINS + 1);
    localparam int RW   = $clog2(MAX_SAMPLES + MAX_BINS + 1);
    localparam int SPD  = COLUMNS * (1 << BW);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_FETCH  = 12'b0000_0000_0010,
        ST_SCAN   = 12'b0000_0000_0100,
        ST_SCANE  = 12'b0000_0000_1000,
        ST_WRAP   = 12'b0000_0001_0000,
        ST_DIVIDE = 12'b0000_0010_0000,
        ST_SELRD  = 12'b0000_0100_0000,
        ST_SELWR  = 12'b0000_1000_0000,
        ST_BEND   = 12'b0001_0000_0000,
        ST_SRD    = 12'b0010_0000_0000,
        ST_SCMP   = 12'b0100_0000_0000,
        ST_FINISH = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] sample_mem [MAX_SAMPLES];
    logic [31:0] scratch_mem [MAX_SAMPLES];
    logic [31:0] split_mem [SPD];
    logic [CNTW-1:0] cnt_mem [COLUMNS];
    logic [COLUMNS-1:0] cnt_vld_reg;

    logic [8:0]  bin_count_reg;
    logic [2:0]  op_reg;
    logic [5:0]  col_reg;
    logic [31:0] val_reg;
    logic [8:0]  idx_reg;
    logic [CNTW-1:0] cnt_rd_reg;
    logic [STW-1:0] smp_total_reg, smp_total_next;

    logic [STW-1:0] scan_reg, scan_next;
    logic           sv_reg;
    logic [31:0]    smp_q_reg, scr_q_reg, spl_q_reg;
    logic [31:0]    best_reg, best_next, prev_reg, prev_next;
    logic           found_reg, found_next, have_prev_reg, have_prev_next;
    logic [STW-1:0] u_reg, u_next;

    logic           many_reg, many_next;
    logic [CNTW-1:0] target_reg, target_next, i_reg, i_next, bins_reg, bins_next;
    logic [STW-1:0] q_reg, q_next;
    logic [RW-1:0]  r_reg, r_next;

    logic [CNTW-1:0] lo_reg, lo_next, len_reg, len_next, mid_reg, mid_next;

    logic [8:0]  wbin_reg, wbin_next, wtot_reg, wtot_next;
    logic        wst_reg, wst_next;
    logic        out_valid_reg;
    logic [8:0]  out_bin_reg, out_tot_reg;
    logic        out_st_reg;

    // memory port controls
    logic            smp_we, scr_we, spl_we, cnt_we;
    logic [SAW-1:0]  smp_waddr, smp_raddr, scr_waddr, scr_raddr;
    logic [31:0]     smp_wdata, scr_wdata, spl_wdata;
    logic [CW+BW-1:0] spl_waddr, spl_raddr;
    logic [CNTW-1:0] cnt_wdata;

    logic [CW-1:0]   col_addr;
    logic            col_ok;
    logic [CNTW-1:0] cnt_cur;
    logic [31:0]     smp_key, qkey;
    logic            take;
    logic [CNTW-1:0] half;
    logic [CNTW-1:0] bins_clamped;

    assign in_stall    = (state_reg != ST_IDLE);
    assign take        = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign bin         = out_bin_reg;
    assign split_total = out_tot_reg;
    assign status      = out_st_reg;

    assign col_addr = CW'(col_reg);
    assign col_ok   = 32'(col_reg) < COLUMNS;
    assign cnt_cur  = cnt_vld_reg[col_addr] ? cnt_rd_reg : '0;
    assign smp_key  = order_key(smp_q_reg);
    assign qkey     = order_key(val_reg);
    assign half     = len_reg >> 1;

    always_comb
    begin
        if (int'(bin_count_reg) < 2)
            bins_clamped = CNTW'(2);
        else if (int'(bin_count_reg) > MAX_BINS)
            bins_clamped = CNTW'(MAX_BINS);
        else
            bins_clamped = CNTW'(bin_count_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        smp_total_next = smp_total_reg;
        scan_next      = scan_reg;
        best_next      = best_reg;
        prev_next      = prev_reg;
        found_next     = found_reg;
        have_prev_next = have_prev_reg;
        u_next         = u_reg;
        many_next      = many_reg;
        target_next    = target_reg;
        i_next         = i_reg;
        bins_next      = bins_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        len_next       = len_reg;
        mid_next       = mid_reg;
        wbin_next      = wbin_reg;
        wtot_next      = wtot_reg;
        wst_next       = wst_reg;
        smp_we    = 1'b0;
        smp_waddr = smp_total_reg[SAW-1:0];
        smp_wdata = val_reg;
        smp_raddr = scan_reg[SAW-1:0];
        scr_we    = 1'b0;
        scr_waddr = u_reg[SAW-1:0];
        scr_wdata = best_reg;
        scr_raddr = many_reg ? q_reg[SAW-1:0] : SAW'(i_reg);
        spl_we    = 1'b0;
        spl_waddr = {col_addr, BW'(idx_reg)};
        spl_wdata = val_reg;
        spl_raddr = {col_addr, BW'(lo_reg + half)};
        cnt_we    = 1'b0;
        cnt_wdata = target_reg;

        // compare unit: smallest key above the previous one
        if (sv_reg && (!have_prev_reg || smp_key > prev_reg) &&
            (!found_reg || smp_key < best_reg))
        begin
            best_next  = smp_key;
            found_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                wbin_next  = '0;
                wtot_next  = '0;
                wst_next   = 1'b0;
                state_next = ST_FINISH;
                if (op_reg == OP_LOAD)
                begin
                    if (!is_nan(val_reg))
                    begin
                        if (int'(smp_total_reg) >= MAX_SAMPLES)
                            wst_next = 1'b1;
                        else
                        begin
                            smp_we         = 1'b1;
                            smp_total_next = smp_total_reg + 1'b1;
                        end
                    end
                end
                else if (col_ok)
                begin
                    wtot_next = 9'(cnt_cur);
                    case (op_reg)
                        OP_BUILD:
                        begin
                            scan_next      = '0;
                            u_next         = '0;
                            found_next     = 1'b0;
                            have_prev_next = 1'b0;
                            bins_next      = bins_clamped;
                            state_next     = (smp_total_reg == '0) ? ST_WRAP : ST_SCAN;
                        end
                        OP_QUERY:
                        begin
                            if (is_nan(val_reg) || cnt_cur == '0)
                                wbin_next = 9'(cnt_cur);
                            else
                            begin
                                lo_next    = '0;
                                len_next   = cnt_cur;
                                state_next = ST_SRD;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (int'(idx_reg) < MAX_BINS)
                                spl_we = 1'b1;
                        end
                        OP_SETCNT:
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = (int'(idx_reg) > MAX_BINS) ? CNTW'(MAX_BINS)
                                                                    : CNTW'(idx_reg);
                            wtot_next = 9'(cnt_wdata);
                        end
                        default:
                        begin
                            wtot_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == smp_total_reg - 1'b1)
                    state_next = ST_SCANE;
            end
            ST_SCANE:
            begin
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                if (found_reg)
                begin
                    scr_we         = 1'b1;
                    u_next         = u_reg + 1'b1;
                    prev_next      = best_reg;
                    have_prev_next = 1'b1;
                    found_next     = 1'b0;
                    scan_next      = '0;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    many_next   = 32'(u_reg) > 32'(bins_reg);
                    target_next = (32'(u_reg) > 32'(bins_reg)) ? bins_reg - 1'b1
                                                                : CNTW'(u_reg);
                    i_next      = '0;
                    q_next      = '0;
                    r_next      = RW'(u_reg);
                    if (u_reg == '0)
                        state_next = ST_BEND;
                    else if (32'(u_reg) > 32'(bins_reg))
                        state_next = ST_DIVIDE;
                    else
                        state_next = ST_SELRD;
                end
            end
            ST_DIVIDE:
            begin
                // q tracks (i+1)*U/bins, remainder kept below bins
                if (r_reg >= RW'(bins_reg))
                begin
                    r_next = r_reg - RW'(bins_reg);
                    q_next = q_reg + 1'b1;
                end
                else
                    state_next = ST_SELRD;
            end
            ST_SELRD:
            begin
                state_next = ST_SELWR;
            end
            ST_SELWR:
            begin
                spl_we    = 1'b1;
                spl_waddr = {col_addr, BW'(i_reg)};
                spl_wdata = key_to_value(scr_q_reg);
                i_next    = i_reg + 1'b1;
                if (i_reg + 1'b1 == target_reg)
                    state_next = ST_BEND;
                else if (many_reg)
                begin
                    r_next     = r_reg + RW'(u_reg);
                    state_next = ST_DIVIDE;
                end
                else
                    state_next = ST_SELRD;
            end
            ST_BEND:
            begin
                cnt_we         = 1'b1;
                cnt_wdata      = (u_reg == '0) ? '0 : target_reg;
                smp_total_next = '0;
                wtot_next      = 9'(cnt_wdata);
                state_next     = ST_FINISH;
            end
            ST_SRD:
            begin
                mid_next   = lo_reg + half;
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                if (!(qkey < order_key(spl_q_reg)))
                begin
                    lo_next  = mid_reg + 1'b1;
                    len_next = len_reg - half - 1'b1;
                end
                else
                    len_next = half;
                if (len_next == '0)
                begin
                    wbin_next  = 9'(lo_next);
                    state_next = ST_FINISH;
                end
                else
                    state_next = ST_SRD;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_count_reg <= BIN_COUNT_RESET;
            smp_total_reg <= '0;
            cnt_vld_reg   <= '0;
            sv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            smp_total_reg <= smp_total_next;
            found_reg     <= found_next;
            have_prev_reg <= have_prev_next;
            sv_reg        <= (state_reg == ST_SCAN);
            if (cfg_write_en)
                bin_count_reg <= cfg_write_data;
            if (cnt_we)
                cnt_vld_reg[col_addr] <= 1'b1;
            if (state_reg == ST_FINISH && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg     <= operation;
            col_reg    <= column;
            val_reg    <= value;
            idx_reg    <= index;
            cnt_rd_reg <= cnt_mem[CW'(column)];
        end
        scan_reg   <= scan_next;
        best_reg   <= best_next;
        prev_reg   <= prev_next;
        u_reg      <= u_next;
        many_reg   <= many_next;
        target_reg <= target_next;
        i_reg      <= i_next;
        bins_reg   <= bins_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        lo_reg     <= lo_next;
        len_reg    <= len_next;
        mid_reg    <= mid_next;
        wbin_reg   <= wbin_next;
        wtot_reg   <= wtot_next;
        wst_reg    <= wst_next;
        if (state_reg == ST_FINISH && (!out_valid_reg || !out_stall))
        begin
            out_bin_reg <= wbin_reg;
            out_tot_reg <= wtot_reg;
            out_st_reg  <= wst_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_we)
            sample_mem[smp_waddr] <= smp_wdata;
        smp_q_reg <= sample_mem[smp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scratch_mem[scr_waddr] <= scr_wdata;
        scr_q_reg <= scratch_mem[scr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (spl_we)
            split_mem[spl_waddr] <= spl_wdata;
        spl_q_reg <= split_mem[spl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[col_addr] <= cnt_wdata;
    end

`ifndef SYNTH
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(smp_total_reg) <= MAX_SAMPLES)
        else $error("sample count past capacity");
    a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg == ST_FETCH)
        else $error("accepted transfer not dispatched");
    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCMP |-> len_reg != '0)
        else $error("search step on empty range");
    a_select_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SELWR |-> i_reg < target_reg)
        else $error("split write past target");
`endif

endmodule

// ----- tb/testbench.sv -----
// testbench for quantile_feature_binner: directed table with some fixed expectations,
// random traffic of all ops vs a behavioral predictor. Depends on qfb_pkg and the RTL.
module testbench;
    import qfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  col;
        logic [31:0] val;
        logic [8:0]  idx;
        logic        typed;
        logic [8:0]  e_bin;
        logic [8:0]  e_total;
        logic        e_status;
    } row_t;

    typedef struct packed {
        logic [8:0] bin;
        logic [8:0] total;
        logic       status;
    } bin_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [8:0]  cfg_write_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = '0;
    logic [5:0]  column = '0;
    logic [31:0] value = '0;
    logic [8:0]  index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [8:0]  bin;
    logic [8:0]  split_total;
    logic        status;

    // predictor state
    logic [8:0]  bins_reg = BIN_COUNT_RESET;
    logic [31:0] samples[$];
    logic [31:0] split_tab [64][256];
    bit          split_written [64][256];
    logic [8:0]  split_cnt [64];

    bin_result_t pending_results[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    quantile_feature_binner i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .column(column), .value(value), .index(index),
        .out_valid(out_valid), .out_stall(out_stall),
        .bin(bin), .split_total(split_total), .status(status)
    );

    function automatic bit f32_nan(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 0;
    endfunction

    function automatic logic [31:0] sort_key(logic [31:0] v);
        logic [31:0] w;
        w = (v == 32'h8000_0000) ? 32'h0 : v;
        return w[31] ? ~w : {1'b1, w[30:0]};
    endfunction

    function automatic logic [31:0] key_value(logic [31:0] k);
        return k[31] ? {1'b0, k[30:0]} : ~k;
    endfunction

    // a query may only touch split entries that were written
    function automatic bit col_readable(int c);
        for (int i = 0; i < split_cnt[c]; i++)
            if (!split_written[c][i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bin_result_t predict_bin(logic [2:0] op, logic [5:0] col,
                                                logic [31:0] val, logic [8:0] idx);
        bin_result_t r;
        logic [31:0] keys[$];
        logic [31:0] uniq[$];
        int nb, u, lo, len, half, mid;
        r = '0;
        if (op == OP_LOAD) begin
            if (!f32_nan(val)) begin
                if (samples.size() >= MAX_SAMPLES_DEF)
                    r.status = 1'b1;
                else
                    samples = {samples, val};
            end
            return r;
        end
        if (op > OP_SETCNT)
            return r;
        case (op)
            OP_BUILD: begin
                foreach (samples[i])
                    keys = {keys, sort_key(samples[i])};
                keys.sort();
                foreach (keys[i])
                    if (uniq.size() == 0 || uniq[$] != keys[i])
                        uniq = {uniq, keys[i]};
                nb = int'(bins_reg);
                if (nb < 2) nb = 2;
                if (nb > MAX_BINS_DEF) nb = MAX_BINS_DEF;
                u = uniq.size();
                if (u <= nb) begin
                    for (int i = 0; i < u; i++) begin
                        split_tab[col][i] = key_value(uniq[i]);
                        split_written[col][i] = 1'b1;
                    end
                    split_cnt[col] = 9'(u);
                end else begin
                    for (int i = 0; i + 1 < nb; i++) begin
                        split_tab[col][i] = key_value(uniq[(i + 1) * u / nb]);
                        split_written[col][i] = 1'b1;
                    end
                    split_cnt[col] = 9'(nb - 1);
                end
                samples.delete();
            end
            OP_QUERY: begin
                if (f32_nan(val)) begin
                    r.bin = split_cnt[col];
                end else begin
                    lo = 0;
                    len = int'(split_cnt[col]);
                    while (len > 0) begin
                        half = len / 2;
                        mid = lo + half;
                        if (!(sort_key(val) < sort_key(split_tab[col][mid]))) begin
                            lo = mid + 1;
                            len -= half + 1;
                        end else begin
                            len = half;
                        end
                    end
                    r.bin = 9'(lo);
                end
            end
            OP_WRITE: begin
                if (idx < MAX_BINS_DEF) begin
                    split_tab[col][idx] = val;
                    split_written[col][idx] = 1'b1;
                end
            end
            default: split_cnt[col] = (int'(idx) > MAX_BINS_DEF) ? 9'(MAX_BINS_DEF) : idx;
        endcase
        r.total = split_cnt[col];
        return r;
    endfunction

    // one item on the input channel; the expectation is queued at the transfer
    task automatic issue(row_t row);
        bin_result_t r;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= row.op;
        column <= row.col;
        value <= row.val;
        index <= row.idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_bin(row.op, row.col, row.val, row.idx);
        if (row.typed)
            r = '{bin: row.e_bin, total: row.e_total, status: row.e_status};
        pending_results = {pending_results, r};
    endtask

    task automatic send(logic [2:0] op, logic [5:0] col, logic [31:0] val, logic [8:0] idx);
        issue('{op: op, col: col, val: val, idx: idx, typed: 1'b0,
                e_bin: 9'd0, e_total: 9'd0, e_status: 1'b0});
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_bins(logic [8:0] b);
        drain();
        repeat (4) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= b;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        bins_reg = b;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h7F80_0000 | $urandom_range(1, 32'h7F_FFFF) | ($urandom_range(0, 1) << 31);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0;
            3: return $urandom_range(0, 1) ? 32'hFF80_0000 : 32'h7F80_0000;
            default: return {1'($urandom_range(0, 1)), 8'd127 + 8'($urandom_range(0, 4)),
                             3'($urandom_range(0, 7)), 20'd0};
        endcase
    endfunction

    function automatic logic [31:0] query_value(int c);
        if (split_cnt[c] != 0 && $urandom_range(0, 2) == 0)
            return split_tab[c][$urandom_range(0, split_cnt[c] - 1)]
                   ^ ($urandom_range(0, 1) ? 32'h1 : 32'h0);
        return rand_value();
    endfunction

    task automatic random_query(int c);
        logic [31:0] v;
        v = query_value(c);
        if (!col_readable(c))
            v = 32'h7FC0_0000 | $urandom_range(0, 32'h3F_FFFF);
        send(OP_QUERY, 6'(c), v, 9'($urandom_range(0, 511)));
    endtask

    task automatic random_phase(int n);
        int sent, c, m;
        sent = 0;
        while (sent < n) begin
            c = $urandom_range(0, 63);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    m = $urandom_range(1, 30);
                    for (int i = 0; i < m; i++)
                        send(OP_LOAD, 6'($urandom_range(0, 63)), rand_value(),
                             9'($urandom_range(0, 511)));
                    send(OP_BUILD, 6'(c), $urandom(), 9'($urandom_range(0, 511)));
                    m += 1;
                    for (int i = $urandom_range(1, 6); i > 0; i--) begin
                        random_query(c);
                        m++;
                    end
                    sent += m;
                end
                6: begin
                    send(OP_WRITE, 6'(c), rand_value(),
                         9'($urandom_range(0, 7) == 0 ? $urandom_range(256, 511)
                                                      : $urandom_range(0, 255)));
                    sent++;
                end
                7: begin
                    send(OP_SETCNT, 6'(c), $urandom(), 9'($urandom_range(0, 7) == 0
                         ? $urandom_range(0, 511) : $urandom_range(0, 12)));
                    sent++;
                end
                8: begin
                    random_query(c);
                    sent++;
                end
                default: begin
                    send($urandom_range(0, 1) ? 3'($urandom_range(5, 7)) : OP_LOAD, 6'(c),
                         rand_value(), 9'($urandom_range(0, 511)));
                    sent++;
                end
            endcase
        end
    endtask

    localparam int PLAN_LEN = 21;
    row_t plan [PLAN_LEN] = '{
        '{OP_QUERY,  6'd5,  32'h3F80_0000, 9'd0,   1'b1, 9'd0, 9'd0,   1'b0},
        '{OP_LOAD,   6'd0,  32'h7FC0_0000, 9'd0,   1'b1, 9'd0, 9'd0,   1'b0},
        '{3'd7,      6'd63, 32'hFFFF_FFFF, 9'd511, 1'b1, 9'd0, 9'd0,   1'b0},
        '{OP_WRITE,  6'd1,  32'h3F80_0000, 9'd0,   1'b1, 9'd0, 9'd0,   1'b0},
        '{OP_WRITE,  6'd1,  32'h4000_0000, 9'd1,   1'b1, 9'd0, 9'd0,   1'b0},
        '{OP_WRITE,  6'd1,  32'hFFFF_FFFF, 9'd511, 1'b1, 9'd0, 9'd0,   1'b0},
        '{OP_SETCNT, 6'd1,  32'h0,         9'd2,   1'b1, 9'd0, 9'd2,   1'b0},
        '{OP_QUERY,  6'd1,  32'h8000_0000, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_QUERY,  6'd1,  32'h3F80_0000, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_QUERY,  6'd1,  32'hFF80_0000, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_QUERY,  6'd1,  32'h7F80_0000, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_QUERY,  6'd1,  32'hFFFF_FFFF, 9'd0,   1'b1, 9'd2, 9'd2,   1'b0},
        '{OP_SETCNT, 6'd63, 32'h0,         9'd511, 1'b1, 9'd0, 9'd256, 1'b0},
        '{OP_SETCNT, 6'd63, 32'h0,         9'd0,   1'b1, 9'd0, 9'd0,   1'b0},
        '{OP_LOAD,   6'd0,  32'h8000_0000, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_LOAD,   6'd0,  32'h0000_0000, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_LOAD,   6'd0,  32'h7F7F_FFFF, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_LOAD,   6'd0,  32'hFF7F_FFFF, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_LOAD,   6'd0,  32'h0000_0001, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_BUILD,  6'd2,  32'h0,         9'd0,   1'b0, 9'd0, 9'd0,   1'b0},
        '{OP_QUERY,  6'd2,  32'h0000_0000, 9'd0,   1'b0, 9'd0, 9'd0,   1'b0}
    };

    // result side: random stall bursts, one long hold on request
    initial begin
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bin %0d split_total %0d status %0d",
                             bin, split_total, status);
            end else begin
                bin_result_t want;
                want = pending_results.pop_front();
                if (want.bin !== bin || want.total !== split_total || want.status !== status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected bin %0d total %0d status %0d, got %0d %0d %0d",
                                 want.bin, want.total, want.status, bin, split_total, status);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        logic [8:0] bin_settings [6];
        bin_settings = '{9'd2, 9'd256, 9'd0, 9'd511, 9'd3, 9'd17};
        foreach (split_cnt[i])
            split_cnt[i] = '0;
        foreach (split_written[i, j])
            split_written[i][j] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            issue(plan[i]);

        // more distinct values than bins, with repeats
        set_bins(9'd5);
        for (int i = 0; i < 40; i++)
            send(OP_LOAD, 6'd0, {1'b0, 8'd128, 3'($urandom_range(0, 7)), 20'd0}, 9'd0);
        send(OP_BUILD, 6'd9, 32'h0, 9'd0);
        for (int i = 0; i < 6; i++)
            random_query(9);

        foreach (bin_settings[p]) begin
            set_bins(bin_settings[p]);
            if (p == 1)
                hold_req = 1'b1;
            if (p == 5)
                idle_en = 1'b0;
            random_phase(190);
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
